// ----- hw/rtl/dsd_pkg.sv -----
package dsd_pkg;

    // Fixed field widths of the request and response items
    localparam int VTX_BITS  = 7;
    localparam int WIN_BITS  = 16;
    localparam int DIST_BITS = 32;

    localparam logic [DIST_BITS-1:0] INFINITY = '1;

    // Request kinds
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // Response status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Configuration port: one 32-bit register per word
    localparam int PADDR_BITS = 3;
    localparam logic [PADDR_BITS-3:0] REG_VERTEX_COUNT = '0;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [VTX_BITS-1:0] edge_tail;
        logic [VTX_BITS-1:0] edge_head;
        logic [WIN_BITS-1:0] edge_cost;
        logic [VTX_BITS-1:0] source_vertex;
        logic [VTX_BITS-1:0] query_vertex;
    } req_item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [DIST_BITS-1:0] distance;
        logic                 reached;
    } rsp_item_t;

endpackage

// ----- hw/rtl/dsd_ram.sv -----
module dsd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/dijkstra_shortest_distances.sv -----
// Channel    Direction  Handshake               Payload
// req        in         req_valid / req_ready   dsd_pkg::req_item_t (one request)
// rsp        out        rsp_valid / rsp_ready   dsd_pkg::rsp_item_t (one per request)
// apb        in/out     psel, penable, pwrite   vertex_count at byte address 0
//
// Scans: a load walks the edge store once to find a parallel edge. Each
//   round of a run walks every stored edge through the single read port
//   of the edge store, followed by a read/add/compare pipeline that must
//   drain before the round commits. req_ready is high only while the
//   sequencer is idle.
// Reset: control, edge count and settled flags clear at once; vertex_count
//   returns to 64. The edge and distance memories are not cleared.
// Stalls: a finished transaction waits in the response register; the next
//   request is taken meanwhile, and its result waits in the sequencer.
module dijkstra_shortest_distances #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  dsd_pkg::req_item_t              req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output dsd_pkg::rsp_item_t              rsp_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dsd_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    import dsd_pkg::*;

    localparam int VIDX_W = $clog2(MAX_VERTICES + 1);
    localparam int VTAB   = 1 << VIDX_W;
    localparam int ET_W   = $clog2(MAX_EDGES + 1);
    localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EDGE_W = 2 * VTX_BITS + WEIGHT_BITS;
    localparam int VTX_MAXVAL = (1 << VTX_BITS) - 1;

    localparam logic [ET_W-1:0] EDGE_LIMIT = ET_W'(MAX_EDGES);
    localparam logic [VTX_BITS-1:0] VTX_LIMIT =
        VTX_BITS'((MAX_VERTICES > VTX_MAXVAL) ? VTX_MAXVAL : MAX_VERTICES);

    // Sequencer states
    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_LOAD_SCAN  = 4'd1;
    localparam logic [3:0] ST_LOAD_WRITE = 4'd2;
    localparam logic [3:0] ST_RUN_INIT   = 4'd3;
    localparam logic [3:0] ST_RUN_SCAN   = 4'd4;
    localparam logic [3:0] ST_RUN_COMMIT = 4'd5;
    localparam logic [3:0] ST_QUERY_READ = 4'd6;
    localparam logic [3:0] ST_QUERY_WAIT = 4'd7;
    localparam logic [3:0] ST_DONE       = 4'd8;

    // A vertex number is valid when it lies in 1..n
    function automatic logic vtx_ok(input logic [VTX_BITS-1:0] v,
                                    input logic [VTX_BITS-1:0] n);
        return (v != '0) && (v <= n);
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [3:0]             state_reg, state_next;
    req_item_t              req_reg, req_next;
    rsp_item_t              res_reg, res_next;
    logic [VTX_BITS-1:0]    vertex_count_reg;
    logic [ET_W-1:0]        edge_total_reg, edge_total_next;
    logic [ET_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                   found_reg, found_next;
    logic [WEIGHT_BITS-1:0] load_weight_reg, load_weight_next;
    logic [VTX_BITS-1:0]    round_reg, round_next;
    logic [VTAB-1:0]        settled_reg, settled_next;
    logic                   best_found_reg, best_found_next;
    logic [DIST_BITS-1:0]   best_dist_reg, best_dist_next;
    logic [VTX_BITS-1:0]    best_head_reg, best_head_next;
    logic [VTX_BITS-1:0]    best_tail_reg, best_tail_next;

    // Scan pipeline: edge read, distance read, saturating add, compare
    logic                   scan_pv_reg;
    logic                   rp2_valid_reg;
    logic [VTX_BITS-1:0]    rp2_head_reg, rp2_tail_reg;
    logic [WEIGHT_BITS-1:0] rp2_weight_reg;
    logic                   rp3_valid_reg;
    logic [DIST_BITS-1:0]   rp3_sum_reg;
    logic [VTX_BITS-1:0]    rp3_head_reg, rp3_tail_reg;

    // Response register
    logic                   rsp_valid_reg;
    rsp_item_t              rsp_data_reg;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic                   edge_we;
    logic [EA_W-1:0]        edge_waddr, edge_raddr;
    logic [EDGE_W-1:0]      edge_wdata, edge_rdata;
    logic                   dist_we;
    logic [VIDX_W-1:0]      dist_waddr, dist_raddr;
    logic [DIST_BITS-1:0]   dist_wdata, dist_rdata;

    dsd_ram #(
        .WIDTH  (EDGE_W),
        .DEPTH  (MAX_EDGES),
        .ADDR_W (EA_W)
    ) u_edge_ram (
        .clk    (clk),
        .we     (edge_we),
        .waddr  (edge_waddr),
        .wdata  (edge_wdata),
        .raddr  (edge_raddr),
        .rdata  (edge_rdata)
    );

    // Indexed by vertex number; entry 0 is never used
    dsd_ram #(
        .WIDTH  (DIST_BITS),
        .DEPTH  (MAX_VERTICES + 1),
        .ADDR_W (VIDX_W)
    ) u_dist_ram (
        .clk    (clk),
        .we     (dist_we),
        .waddr  (dist_waddr),
        .wdata  (dist_wdata),
        .raddr  (dist_raddr),
        .rdata  (dist_rdata)
    );

    // ------------------------------------------------------------------
    // Derived values
    // ------------------------------------------------------------------
    logic [VTX_BITS-1:0]    n_vtx;
    logic [VTX_BITS-1:0]    e_tail, e_head;
    logic [WEIGHT_BITS-1:0] e_weight;
    logic [VIDX_W-1:0]      e_tail_idx, e_head_idx;
    logic [VIDX_W-1:0]      src_idx, q_idx, best_head_idx;
    logic                   scan_issue, scan_busy;
    logic                   s1_elig;
    logic [DIST_BITS:0]     sum_wide;
    logic [DIST_BITS-1:0]   sum_sat;
    logic                   take;
    logic                   rsp_free;
    logic                   cfg_sel, cfg_write;

    // Effective vertex count is capped by the vertex capacity
    assign n_vtx = (vertex_count_reg > VTX_LIMIT) ? VTX_LIMIT : vertex_count_reg;

    assign e_tail   = edge_rdata[EDGE_W-1 -: VTX_BITS];
    assign e_head   = edge_rdata[WEIGHT_BITS +: VTX_BITS];
    assign e_weight = edge_rdata[WEIGHT_BITS-1:0];

    assign e_tail_idx    = VIDX_W'(e_tail);
    assign e_head_idx    = VIDX_W'(e_head);
    assign src_idx       = VIDX_W'(req_reg.source_vertex);
    assign q_idx         = VIDX_W'(req_reg.query_vertex);
    assign best_head_idx = VIDX_W'(best_head_reg);

    // Walk the edge store in load order, one entry a cycle
    assign scan_issue = ((state_reg == ST_LOAD_SCAN) || (state_reg == ST_RUN_SCAN))
                        && (scan_idx_reg < edge_total_reg);
    assign edge_raddr = scan_idx_reg[EA_W-1:0];
    assign scan_busy  = scan_issue || scan_pv_reg || rp2_valid_reg || rp3_valid_reg;

    // Stage 1: candidate edge leaves a settled vertex for an unsettled one,
    // and both ends lie within the current vertex count
    assign s1_elig = scan_pv_reg && (state_reg == ST_RUN_SCAN)
                     && vtx_ok(e_tail, n_vtx) && vtx_ok(e_head, n_vtx)
                     && settled_reg[e_tail_idx] && !settled_reg[e_head_idx];

    // Stage 2: saturating distance plus weight
    assign sum_wide = {1'b0, dist_rdata} + (DIST_BITS + 1)'(rp2_weight_reg);
    assign sum_sat  = (sum_wide >= {1'b0, INFINITY}) ? INFINITY : sum_wide[DIST_BITS-1:0];

    // Stage 3: strictly cheaper wins; on a tie the lower tail wins, and within
    // one tail the earlier edge already holds the slot
    assign take = rp3_valid_reg
                  && (!best_found_reg
                      || (rp3_sum_reg < best_dist_reg)
                      || ((rp3_sum_reg == best_dist_reg) && (rp3_tail_reg < best_tail_reg)));

    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign cfg_sel   = (paddr[PADDR_BITS-1:2] == REG_VERTEX_COUNT);
    assign cfg_write = psel && penable && pwrite && cfg_sel;
    assign pready    = 1'b1;
    assign prdata    = cfg_sel ? 32'(vertex_count_reg) : '0;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        res_next         = res_reg;
        edge_total_next  = edge_total_reg;
        scan_idx_next    = scan_idx_reg;
        found_next       = found_reg;
        load_weight_next = load_weight_reg;
        round_next       = round_reg;
        settled_next     = settled_reg;
        best_found_next  = best_found_reg;
        best_dist_next   = best_dist_reg;
        best_head_next   = best_head_reg;
        best_tail_next   = best_tail_reg;

        edge_we    = 1'b0;
        edge_waddr = edge_total_reg[EA_W-1:0];
        edge_wdata = {req_reg.edge_tail, req_reg.edge_head, load_weight_reg};
        dist_we    = 1'b0;
        dist_waddr = best_head_idx;
        dist_wdata = best_dist_reg;
        dist_raddr = e_tail_idx;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req_data;
                    res_next = '0;
                    case (req_data.req_type)
                        REQ_LOAD:
                        begin
                            // Range check comes before the full check
                            if (!vtx_ok(req_data.edge_tail, n_vtx)
                                || !vtx_ok(req_data.edge_head, n_vtx))
                            begin
                                res_next.status = STATUS_RANGE;
                                state_next      = ST_DONE;
                            end
                            else if (edge_total_reg == EDGE_LIMIT)
                            begin
                                res_next.status = STATUS_FULL;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                scan_idx_next    = '0;
                                found_next       = 1'b0;
                                load_weight_next = WEIGHT_BITS'(req_data.edge_cost);
                                state_next       = ST_LOAD_SCAN;
                            end
                        end
                        REQ_RUN:
                        begin
                            if (!vtx_ok(req_data.source_vertex, n_vtx))
                            begin
                                res_next.status = STATUS_RANGE;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_RUN_INIT;
                            end
                        end
                        REQ_QUERY:
                        begin
                            if (!vtx_ok(req_data.query_vertex, n_vtx))
                            begin
                                res_next.status   = STATUS_RANGE;
                                res_next.distance = INFINITY;
                                state_next        = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_QUERY_READ;
                            end
                        end
                        default:
                        begin
                            edge_total_next = '0;
                            state_next      = ST_DONE;
                        end
                    endcase
                end
            end

            ST_LOAD_SCAN:
            begin
                if (scan_issue)
                begin
                    scan_idx_next = scan_idx_reg + ET_W'(1);
                end
                // The first parallel edge sets the weight
                if (scan_pv_reg && !found_reg
                    && (e_tail == req_reg.edge_tail) && (e_head == req_reg.edge_head))
                begin
                    found_next       = 1'b1;
                    load_weight_next = e_weight;
                end
                if (!scan_issue && !scan_pv_reg)
                begin
                    state_next = ST_LOAD_WRITE;
                end
            end

            ST_LOAD_WRITE:
            begin
                edge_we         = 1'b1;
                edge_total_next = edge_total_reg + ET_W'(1);
                state_next      = ST_DONE;
            end

            ST_RUN_INIT:
            begin
                settled_next          = '0;
                settled_next[src_idx] = 1'b1;
                dist_we               = 1'b1;
                dist_waddr            = src_idx;
                dist_wdata            = '0;
                round_next            = VTX_BITS'(1);
                scan_idx_next         = '0;
                best_found_next       = 1'b0;
                state_next            = (n_vtx == VTX_BITS'(1)) ? ST_DONE : ST_RUN_SCAN;
            end

            ST_RUN_SCAN:
            begin
                if (scan_issue)
                begin
                    scan_idx_next = scan_idx_reg + ET_W'(1);
                end
                if (take)
                begin
                    best_found_next = 1'b1;
                    best_dist_next  = rp3_sum_reg;
                    best_head_next  = rp3_head_reg;
                    best_tail_next  = rp3_tail_reg;
                end
                if (!scan_busy)
                begin
                    state_next = ST_RUN_COMMIT;
                end
            end

            ST_RUN_COMMIT:
            begin
                if (best_found_reg)
                begin
                    settled_next[best_head_idx] = 1'b1;
                    dist_we                     = 1'b1;
                end
                // Stop when nothing is left to settle or all rounds are done
                if (!best_found_reg
                    || (({1'b0, round_reg} + (VTX_BITS + 1)'(1)) >= {1'b0, n_vtx}))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    round_next      = round_reg + VTX_BITS'(1);
                    scan_idx_next   = '0;
                    best_found_next = 1'b0;
                    state_next      = ST_RUN_SCAN;
                end
            end

            ST_QUERY_READ:
            begin
                dist_raddr = q_idx;
                state_next = ST_QUERY_WAIT;
            end

            ST_QUERY_WAIT:
            begin
                res_next.reached  = settled_reg[q_idx];
                res_next.distance = settled_reg[q_idx] ? dist_rdata : INFINITY;
                state_next        = ST_DONE;
            end

            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            vertex_count_reg <= VTX_BITS'(64);
            edge_total_reg   <= '0;
            settled_reg      <= '0;
            scan_pv_reg      <= 1'b0;
            rp2_valid_reg    <= 1'b0;
            rp3_valid_reg    <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            settled_reg    <= settled_next;
            scan_pv_reg    <= scan_issue;
            rp2_valid_reg  <= s1_elig;
            rp3_valid_reg  <= rp2_valid_reg;
            if (cfg_write)
            begin
                vertex_count_reg <= pwdata[VTX_BITS-1:0];
            end
            // Hand the finished result over; drop it once taken
            if ((state_reg == ST_DONE) && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and datapath registers
    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        res_reg         <= res_next;
        scan_idx_reg    <= scan_idx_next;
        found_reg       <= found_next;
        load_weight_reg <= load_weight_next;
        round_reg       <= round_next;
        best_found_reg  <= best_found_next;
        best_dist_reg   <= best_dist_next;
        best_head_reg   <= best_head_next;
        best_tail_reg   <= best_tail_next;
        rp2_head_reg    <= e_head;
        rp2_tail_reg    <= e_tail;
        rp2_weight_reg  <= e_weight;
        rp3_sum_reg     <= sum_sat;
        rp3_head_reg    <= rp2_head_reg;
        rp3_tail_reg    <= rp2_tail_reg;
        if ((state_reg == ST_DONE) && rsp_free)
        begin
            rsp_data_reg <= res_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= EDGE_LIMIT)
        else $error("edge count beyond store capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN_COMMIT && best_found_reg) |-> !settled_reg[best_head_idx])
        else $error("run picked an already settled vertex");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN_SCAN || state_reg == ST_RUN_COMMIT) |-> settled_reg[src_idx])
        else $error("source vertex not settled during run");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && rsp_valid_reg && !rsp_ready) |=> (state_reg == ST_DONE))
        else $error("result left the sequencer while response register was full");

endmodule
